// File: rtl/vcfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vcfe_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int TIMER_W     = 16;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    // Operation codes of a command transaction
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Reply status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_START_MARK     = 2'd1;
    localparam logic [1:0] REG_END_MARK       = 2'd2;

    localparam logic [BYTE_W-1:0] START_MARK_RESET = 8'd204;
    localparam logic [BYTE_W-1:0] END_MARK_RESET   = 8'd221;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HUNT    = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [BYTE_W-1:0]  command_code;
        logic [BYTE_W-1:0]  param_low;
        logic [BYTE_W-1:0]  param_high;
        logic [TIMER_W-1:0] timeout_ms;
        logic [BYTE_W-1:0]  rx_byte;
    } cmd_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_data;
        logic              last;
        logic              reply_done;
        logic [1:0]        reply_status;
        logic [BYTE_W-1:0] reply_address;
        logic [BYTE_W-1:0] reply_function;
        logic [BYTE_W-1:0] reply_param_low;
        logic [BYTE_W-1:0] reply_param_high;
    } rsp_t;

    // Work handed from the exchange core to the result stage
    typedef struct packed {
        logic                               frame;
        logic                               reply;
        logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_bytes;
        logic [1:0]                         status;
        logic [BYTE_W-1:0]                  address;
        logic [BYTE_W-1:0]                  function_code;
        logic [BYTE_W-1:0]                  param_low;
        logic [BYTE_W-1:0]                  param_high;
    } load_t;

endpackage

`default_nettype wire

// File: rtl/vcfe_core.sv
`timescale 1ns / 1ps
`default_nettype none

module vcfe_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire vcfe_pkg::cmd_t cmd,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data,
    output vcfe_pkg::load_t     load
);

    logic [vcfe_pkg::BYTE_W-1:0]  device_address_reg;
    logic [vcfe_pkg::BYTE_W-1:0]  start_mark_reg;
    logic [vcfe_pkg::BYTE_W-1:0]  end_mark_reg;

    vcfe_pkg::phase_t             phase_reg, phase_next;
    logic [vcfe_pkg::TIMER_W-1:0] countdown_reg, countdown_next;
    logic [vcfe_pkg::TIMER_W-1:0] saved_timeout_reg, saved_timeout_next;
    logic [vcfe_pkg::IDX_W-1:0]   byte_index_reg, byte_index_next;
    logic [15:0]                  running_sum_reg, running_sum_next;
    logic [vcfe_pkg::BYTE_W-1:0]  reply_bytes_reg [vcfe_pkg::FRAME_BYTES];

    logic                         store_we;
    logic [15:0]                  frame_sum;
    logic [15:0]                  sum_plus_byte;
    logic                         frame_good;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= '0;
            start_mark_reg     <= vcfe_pkg::START_MARK_RESET;
            end_mark_reg       <= vcfe_pkg::END_MARK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vcfe_pkg::REG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                vcfe_pkg::REG_START_MARK:     start_mark_reg     <= cfg_data;
                vcfe_pkg::REG_END_MARK:       end_mark_reg       <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Sum of the six header bytes of an outgoing frame
    assign frame_sum = {8'd0, start_mark_reg} + {8'd0, device_address_reg}
                     + {8'd0, cmd.command_code} + {8'd0, cmd.param_low}
                     + {8'd0, cmd.param_high} + {8'd0, end_mark_reg};

    assign sum_plus_byte = running_sum_reg + {8'd0, cmd.rx_byte};

    // Final check: received sum bytes vs running sum, end mark vs register
    assign frame_good = (reply_bytes_reg[6] == running_sum_reg[7:0])
                     && (cmd.rx_byte == running_sum_reg[15:8])
                     && (reply_bytes_reg[5] == end_mark_reg);

    // Next state and result for one transaction
    always_comb
    begin
        phase_next         = phase_reg;
        countdown_next     = countdown_reg;
        saved_timeout_next = saved_timeout_reg;
        byte_index_next    = byte_index_reg;
        running_sum_next   = running_sum_reg;
        store_we           = 1'b0;

        load               = '0;
        load.frame_bytes[0] = start_mark_reg;
        load.frame_bytes[1] = device_address_reg;
        load.frame_bytes[2] = cmd.command_code;
        load.frame_bytes[3] = cmd.param_low;
        load.frame_bytes[4] = cmd.param_high;
        load.frame_bytes[5] = end_mark_reg;
        load.frame_bytes[6] = frame_sum[7:0];
        load.frame_bytes[7] = frame_sum[15:8];

        if (accept)
        begin
            unique case (cmd.operation)
                vcfe_pkg::OP_SEND:
                begin
                    load.frame         = 1'b1;
                    saved_timeout_next = cmd.timeout_ms;
                    countdown_next     = cmd.timeout_ms;
                    phase_next         = vcfe_pkg::PH_HUNT;
                    byte_index_next    = '0;
                    running_sum_next   = '0;
                end
                vcfe_pkg::OP_BYTE:
                begin
                    if (phase_reg == vcfe_pkg::PH_HUNT)
                    begin
                        if (cmd.rx_byte == start_mark_reg)
                        begin
                            running_sum_next = {8'd0, cmd.rx_byte};
                            byte_index_next  = vcfe_pkg::IDX_W'(1);
                            countdown_next   = saved_timeout_reg;
                            phase_next       = vcfe_pkg::PH_COLLECT;
                        end
                    end
                    else if (phase_reg == vcfe_pkg::PH_COLLECT)
                    begin
                        store_we       = 1'b1;
                        countdown_next = saved_timeout_reg;
                        if (byte_index_reg < vcfe_pkg::IDX_W'(6))
                        begin
                            running_sum_next = sum_plus_byte;
                        end
                        if (byte_index_reg != vcfe_pkg::IDX_W'(vcfe_pkg::FRAME_BYTES - 1))
                        begin
                            byte_index_next = byte_index_reg + vcfe_pkg::IDX_W'(1);
                        end
                        else
                        begin
                            load.reply      = 1'b1;
                            load.status     = frame_good ? vcfe_pkg::ST_OK : vcfe_pkg::ST_BAD;
                            load.address       = reply_bytes_reg[1];
                            load.function_code = reply_bytes_reg[2];
                            load.param_low     = reply_bytes_reg[3];
                            load.param_high    = reply_bytes_reg[4];
                            phase_next      = vcfe_pkg::PH_IDLE;
                            byte_index_next = '0;
                        end
                    end
                end
                vcfe_pkg::OP_TICK:
                begin
                    if (phase_reg != vcfe_pkg::PH_IDLE)
                    begin
                        if (countdown_reg > vcfe_pkg::TIMER_W'(1))
                        begin
                            countdown_next = countdown_reg - vcfe_pkg::TIMER_W'(1);
                        end
                        else
                        begin
                            countdown_next  = '0;
                            load.reply      = 1'b1;
                            load.status     = vcfe_pkg::ST_TIMEOUT;
                            phase_next      = vcfe_pkg::PH_IDLE;
                            byte_index_next = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Exchange state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= vcfe_pkg::PH_IDLE;
            countdown_reg     <= '0;
            saved_timeout_reg <= '0;
            byte_index_reg    <= '0;
            running_sum_reg   <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            countdown_reg     <= countdown_next;
            saved_timeout_reg <= saved_timeout_next;
            byte_index_reg    <= byte_index_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    // Store collected reply bytes
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            reply_bytes_reg[byte_index_reg] <= cmd.rx_byte;
        end
    end

    a_idle_hunt_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != vcfe_pkg::PH_COLLECT) |-> (byte_index_reg == '0))
        else $error("byte index not cleared outside collection");

    a_collect_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == vcfe_pkg::PH_COLLECT) |-> (byte_index_reg != '0))
        else $error("collection running with zero byte index");

    a_reply_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load.reply |=> (phase_reg == vcfe_pkg::PH_IDLE))
        else $error("exchange did not end after its reply");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(load.reply && load.frame))
        else $error("frame and reply raised together");

endmodule

`default_nettype wire

// File: rtl/vcfe_out.sv
`timescale 1ns / 1ps
`default_nettype none

module vcfe_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire vcfe_pkg::load_t load,
    output logic                 can_load,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output vcfe_pkg::rsp_t       rsp
);

    logic [vcfe_pkg::CNT_W-1:0]                             count_reg;
    logic                                                   reply_mode_reg;
    logic [vcfe_pkg::FRAME_BYTES-1:0][vcfe_pkg::BYTE_W-1:0] shift_reg;
    vcfe_pkg::rsp_t                                         reply_reg;
    vcfe_pkg::rsp_t                                         reply_next;
    vcfe_pkg::rsp_t                                         tx_rsp;
    logic                                                   take;

    assign rsp_valid = (count_reg != '0);
    assign take      = rsp_valid && rsp_ready;
    // Free when empty or when the final pending result leaves now
    assign can_load  = (count_reg == '0)
                    || ((count_reg == vcfe_pkg::CNT_W'(1)) && rsp_ready);

    // Build the transmit result from the head of the shift line
    always_comb
    begin
        tx_rsp          = '0;
        tx_rsp.tx_valid = 1'b1;
        tx_rsp.tx_data  = shift_reg[0];
        tx_rsp.last     = (count_reg == vcfe_pkg::CNT_W'(1));
    end

    // Build the reply result from the handed-over status and fields
    always_comb
    begin
        reply_next                  = '0;
        reply_next.last             = 1'b1;
        reply_next.reply_done       = 1'b1;
        reply_next.reply_status     = load.status;
        reply_next.reply_address    = load.address;
        reply_next.reply_function   = load.function_code;
        reply_next.reply_param_low  = load.param_low;
        reply_next.reply_param_high = load.param_high;
    end

    assign rsp = reply_mode_reg ? reply_reg : tx_rsp;

    // Pending result count and mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            reply_mode_reg <= 1'b0;
        end
        else if (load.frame)
        begin
            count_reg      <= vcfe_pkg::CNT_W'(vcfe_pkg::FRAME_BYTES);
            reply_mode_reg <= 1'b0;
        end
        else if (load.reply)
        begin
            count_reg      <= vcfe_pkg::CNT_W'(1);
            reply_mode_reg <= 1'b1;
        end
        else if (take)
        begin
            count_reg <= count_reg - vcfe_pkg::CNT_W'(1);
        end
    end

    // Frame bytes and reply payload
    always_ff @(posedge clk)
    begin
        if (load.frame)
        begin
            shift_reg <= load.frame_bytes;
        end
        else if (take)
        begin
            shift_reg <= {vcfe_pkg::BYTE_W'(0), shift_reg[vcfe_pkg::FRAME_BYTES-1:1]};
        end

        if (load.reply)
        begin
            reply_reg <= reply_next;
        end
    end

    a_frame_fills_eight: assert property (@(posedge clk) disable iff (!rst_n)
        load.frame |=> (count_reg == vcfe_pkg::CNT_W'(vcfe_pkg::FRAME_BYTES)))
        else $error("frame load did not queue all bytes");

    a_reply_single: assert property (@(posedge clk) disable iff (!rst_n)
        reply_mode_reg |-> (count_reg <= vcfe_pkg::CNT_W'(1)))
        else $error("reply mode with more than one pending result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load.frame || load.reply) |-> can_load)
        else $error("result stage loaded while still busy");

endmodule

`default_nettype wire

// File: rtl/valve_command_frame_exchange.sv
`timescale 1ns / 1ps
`default_nettype none

// A send, last reply byte or timeout shows its result the cycle after acceptance.
// Throughput: one transaction per cycle while the result stage can take work; a send
// occupies the result stage for eight output transactions, a reply for one.
// Reset: asynchronous active low; clears exchange state to idle, restores the default
// address and marks, and empties the result stage. Reply byte storage is not reset.

module valve_command_frame_exchange (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire vcfe_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output vcfe_pkg::rsp_t      rsp,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data
);

    vcfe_pkg::load_t load;
    logic            can_load;
    logic            accept;

    assign cmd_ready = can_load;
    assign accept    = cmd_valid && cmd_ready;

    vcfe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .load      (load)
    );

    vcfe_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .can_load  (can_load),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
